// File: rtl/assert_macros.svh
// Assertion helper macros for the prescaled compare timer.
// Pulled in by the modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define PCMT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that an antecedent leads to a consequent in the next cycle.
`define PCMT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/pcmt_pkg.sv
// Shared types and constants of the prescaled compare timer.
// Used by the controller, the datapath and the top level; no dependencies.
package pcmt_pkg;

   // Opcodes of an input word.
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   // Register offsets inside one timer's window.
   localparam logic [10:0] OFS_COUNT = 11'h000;
   localparam logic [10:0] OFS_MODE  = 11'h010;
   localparam logic [10:0] OFS_COMP  = 11'h020;
   localparam logic [10:0] OFS_HOLD  = 11'h030;

   // Mode word bit positions.
   localparam int MODE_ZRET = 6;
   localparam int MODE_CUE  = 7;
   localparam int MODE_EQIE = 8;
   localparam int MODE_OVIE = 9;
   localparam int MODE_EQUF = 10;
   localparam int MODE_OVFF = 11;
   localparam logic [31:0] MODE_FLAG_MASK = 32'h0000_0C00;

   // Clock select codes in mode bits 1:0.
   localparam logic [1:0] CKS_DIV1    = 2'd0;
   localparam logic [1:0] CKS_DIV16   = 2'd1;
   localparam logic [1:0] CKS_DIV256  = 2'd2;
   localparam logic [1:0] CKS_DIV9437 = 2'd3;

   // Timer slots addressable by the two timer-number bits.
   localparam int TIMER_SLOTS   = 4;
   // Remainder width; the largest divider is below 2**14.
   localparam int PRESCALE_BITS = 14;

   // The slow prescaler and its reciprocal scaled by 2**33, floor(2**33 / 9437).
   localparam logic [13:0] SLOW_DIVISOR = 14'd9437;
   localparam logic [19:0] SLOW_RECIP   = 20'(64'd8589934592 / 64'd9437);
   localparam int          RECIP_SHIFT  = 20;

   localparam logic [16:0] CMP_WRAP  = 17'h1_0000;
   localparam logic [15:0] COUNT_TOP = 16'hFFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REG,
      ST_TICK_SEL,
      ST_DIV,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic capture;
      logic reg_op;
      logic div_load;
      logic div_step;
      logic apply;
      logic next_timer;
      logic emit;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic is_tick;
      logic timer_en;
      logic timer_last;
      logic div_last;
   } status_type;

endpackage

// File: rtl/four_channel_prescaled_compare_timer.sv
// Prescaled compare timer top level: joins pcmt_ctrl and pcmt_dp, uses pcmt_pkg.
// Register read or write: after acceptance the word passes the select, register and finish states.
// Tick batch: each enabled timer passes select, three divider steps and update; each disabled
// timer passes select only; the finish state then loads the result into the output register.
// A finished word waits while the output register holds an untaken word; no new word before.
// Synchronous reset clears all timer state, flags and the output valid.
module four_channel_prescaled_compare_timer import pcmt_pkg::*; #(
   parameter int NUM_TIMERS = 4,
   parameter int TICK_BITS  = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_opcode,
   input  logic [12:0]          req_address,
   input  logic [31:0]          req_write_data,
   input  logic [TICK_BITS-1:0] req_tick_count,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [31:0]          rsp_read_data,
   output logic [3:0]           rsp_irq_lines
);

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   pcmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Timer state and arithmetic.
   pcmt_dp #(
      .NUM_TIMERS (NUM_TIMERS),
      .TICK_BITS  (TICK_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_opcode     (req_opcode),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .req_tick_count (req_tick_count),
      .rsp_read_data  (rsp_read_data),
      .rsp_irq_lines  (rsp_irq_lines)
   );

endmodule

// File: rtl/pcmt_ctrl.sv
// Sequencing state machine of the prescaled compare timer.
// Depends on pcmt_pkg and assert_macros.svh; drives the datapath by commands.
`include "assert_macros.svh"

module pcmt_ctrl import pcmt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // State and output valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_TICK_SEL;
            end
         end
         ST_TICK_SEL: begin
            if (!status.is_tick) begin
               state_in = ST_REG;
            end else if (status.timer_en) begin
               cmd.div_load = 1'b1;
               state_in     = ST_DIV;
            end else if (status.timer_last) begin
               state_in = ST_FINISH;
            end else begin
               cmd.next_timer = 1'b1;
            end
         end
         ST_REG: begin
            cmd.reg_op = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.apply = 1'b1;
            if (status.timer_last) begin
               state_in = ST_FINISH;
            end else begin
               cmd.next_timer = 1'b1;
               state_in       = ST_TICK_SEL;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The output word stays valid until taken, and a new one loads only into a free slot.
   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);

   `PCMT_ASSERT(a_emit_free, !cmd.emit || out_free, "result loaded over a waiting word")
   `PCMT_ASSERT_NEXT(a_div_hold, state_ff == ST_DIV && !status.div_last, state_ff == ST_DIV, "divider left early")
   `PCMT_ASSERT_NEXT(a_upd_next, state_ff == ST_UPDATE && !status.timer_last, state_ff == ST_TICK_SEL, "timer sweep cut short")

endmodule

// File: rtl/pcmt_dp.sv
// Datapath of the prescaled compare timer: timer state, reciprocal prescale divider,
// compare and overflow logic, register access and result word. Depends on pcmt_pkg.
module pcmt_dp import pcmt_pkg::*; #(
   parameter int NUM_TIMERS = 4,
   parameter int TICK_BITS  = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic [1:0]           req_opcode,
   input  logic [12:0]          req_address,
   input  logic [31:0]          req_write_data,
   input  logic [TICK_BITS-1:0] req_tick_count,
   output logic [31:0]          rsp_read_data,
   output logic [3:0]           rsp_irq_lines
);

   localparam int TOT_W = ((TICK_BITS > PRESCALE_BITS) ? TICK_BITS : PRESCALE_BITS) + 1;
   localparam int NXT_W = ((TOT_W > 16) ? TOT_W : 16) + 1;
   // Dividend bits above 2**13 feed the reciprocal product.
   localparam int QY_W  = TOT_W - 13;
   localparam int PRD_W = QY_W + RECIP_SHIFT;
   localparam logic [1:0] DIV_STEPS = 2'd3;

   // Captured input word.
   logic [1:0]           op_ff;
   logic [12:0]          addr_ff;
   logic [31:0]          wdata_ff;
   logic [TICK_BITS-1:0] ticks_ff;

   // Sweep and result registers.
   logic [1:0]  tidx_ff;
   logic [31:0] rd_ff, rd_in;
   logic [3:0]  irq_ff;
   logic [31:0] out_rd_ff;
   logic [3:0]  out_irq_ff;

   // Timer state.
   logic [15:0]              cnt_ff   [TIMER_SLOTS];
   logic [31:0]              mode_ff  [TIMER_SLOTS];
   logic [15:0]              comp_ff  [TIMER_SLOTS];
   logic [15:0]              hold_ff  [TIMER_SLOTS];
   logic [PRESCALE_BITS-1:0] prem_ff  [TIMER_SLOTS];

   // Prescale divider.
   logic [TOT_W-1:0]         div_x_ff;
   logic [QY_W-1:0]          div_qe_ff;
   logic [14:0]              div_r0_ff;
   logic [TOT_W-1:0]         div_q_ff;
   logic [PRESCALE_BITS-1:0] div_r_ff;
   logic [1:0]               div_cnt_ff;

   logic [1:0]               sel;
   logic                     sel_ok;
   logic [31:0]              cur_mode;
   logic [15:0]              cur_cnt;
   logic [15:0]              cur_comp;
   logic [TOT_W-1:0]         dividend;
   logic [PRD_W-1:0]         recip_prod;
   logic [TOT_W-1:0]         back_prod;
   logic [TOT_W-1:0]         slow_rem;
   logic [TOT_W-1:0]         q_fix, q_sel;
   logic [PRESCALE_BITS-1:0] r_fix, r_sel;

   logic [16:0]      cmp_v;
   logic [NXT_W-1:0] nxt, nxt_z;
   logic             hit_eq, hit_ov, irq_bit;
   logic [31:0]      flags;

   assign sel      = (op_ff == OP_TICK) ? tidx_ff : addr_ff[12:11];
   assign sel_ok   = (32'(sel) < NUM_TIMERS);
   assign cur_mode = mode_ff[sel];
   assign cur_cnt  = cnt_ff[sel];
   assign cur_comp = comp_ff[sel];
   assign dividend = TOT_W'(prem_ff[sel]) + TOT_W'(ticks_ff);

   assign status.is_tick    = (op_ff == OP_TICK);
   assign status.timer_en   = cur_mode[MODE_CUE];
   assign status.timer_last = (tidx_ff == 2'(NUM_TIMERS - 1));
   assign status.div_last   = (div_cnt_ff == 2'd1);

   // Quotient estimate by the slow divisor is low by at most two; the
   // remainder against it is then below three divisors.
   assign recip_prod = PRD_W'(div_x_ff[TOT_W-1:13]) * PRD_W'(SLOW_RECIP);
   assign back_prod  = TOT_W'(div_qe_ff) * TOT_W'(SLOW_DIVISOR);
   assign slow_rem   = div_x_ff - back_prod;

   // Final quotient and remainder for the selected prescaler.
   always_comb begin
      if (div_r0_ff >= {SLOW_DIVISOR, 1'b0}) begin
         q_fix = TOT_W'(div_qe_ff) + TOT_W'(2);
         r_fix = PRESCALE_BITS'(div_r0_ff - {SLOW_DIVISOR, 1'b0});
      end else if (div_r0_ff >= {1'b0, SLOW_DIVISOR}) begin
         q_fix = TOT_W'(div_qe_ff) + TOT_W'(1);
         r_fix = PRESCALE_BITS'(div_r0_ff - {1'b0, SLOW_DIVISOR});
      end else begin
         q_fix = TOT_W'(div_qe_ff);
         r_fix = PRESCALE_BITS'(div_r0_ff);
      end
      case (cur_mode[1:0])
         CKS_DIV1: begin
            q_sel = div_x_ff;
            r_sel = '0;
         end
         CKS_DIV16: begin
            q_sel = div_x_ff >> 4;
            r_sel = PRESCALE_BITS'(div_x_ff[3:0]);
         end
         CKS_DIV256: begin
            q_sel = div_x_ff >> 8;
            r_sel = PRESCALE_BITS'(div_x_ff[7:0]);
         end
         default: begin
            q_sel = q_fix;
            r_sel = r_fix;
         end
      endcase
   end

   // Count advance, compare match and overflow.
   always_comb begin
      cmp_v   = (cur_comp == 16'd0) ? CMP_WRAP : {1'b0, cur_comp};
      nxt     = NXT_W'(cur_cnt) + NXT_W'(div_q_ff);
      hit_eq  = (17'(cur_cnt) < cmp_v) && (nxt >= NXT_W'(cmp_v));
      nxt_z   = (hit_eq && cur_mode[MODE_ZRET]) ? nxt - NXT_W'(cmp_v) : nxt;
      hit_ov  = (nxt_z >= NXT_W'(COUNT_TOP));
      flags   = '0;
      flags[MODE_EQUF] = hit_eq;
      flags[MODE_OVFF] = hit_ov;
      irq_bit = (hit_eq && cur_mode[MODE_EQIE]) || (hit_ov && cur_mode[MODE_OVIE]);
   end

   // Register read value.
   always_comb begin
      rd_in = '0;
      if (op_ff == OP_READ && sel_ok) begin
         case (addr_ff[10:0])
            OFS_COUNT: rd_in = {16'd0, cur_cnt};
            OFS_MODE:  rd_in = cur_mode;
            OFS_COMP:  rd_in = {16'd0, cur_comp};
            OFS_HOLD:  rd_in = {16'd0, hold_ff[sel]};
            default:   rd_in = '0;
         endcase
      end
   end

   // Input capture, sweep index, result and divider registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_opcode;
         addr_ff  <= req_address;
         wdata_ff <= req_write_data;
         ticks_ff <= req_tick_count;
         tidx_ff  <= '0;
         rd_ff    <= '0;
         irq_ff   <= '0;
      end else begin
         if (cmd.next_timer) begin
            tidx_ff <= tidx_ff + 2'd1;
         end
         if (cmd.reg_op) begin
            rd_ff <= rd_in;
         end
         if (cmd.apply && irq_bit) begin
            irq_ff[tidx_ff] <= 1'b1;
         end
      end
      // The divider stages run as a pipeline on a held dividend; the third
      // step leaves the final quotient and remainder.
      if (cmd.div_load) begin
         div_x_ff   <= dividend;
         div_cnt_ff <= DIV_STEPS;
      end else if (cmd.div_step) begin
         div_qe_ff  <= recip_prod[PRD_W-1:RECIP_SHIFT];
         div_r0_ff  <= slow_rem[14:0];
         div_q_ff   <= q_sel;
         div_r_ff   <= r_sel;
         div_cnt_ff <= div_cnt_ff - 2'd1;
      end
      if (cmd.emit) begin
         out_rd_ff  <= rd_ff;
         out_irq_ff <= irq_ff;
      end
   end

   // Timer state updates from tick sweeps and register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TIMER_SLOTS; i++) begin
            cnt_ff[i]  <= '0;
            mode_ff[i] <= '0;
            comp_ff[i] <= '0;
            hold_ff[i] <= '0;
            prem_ff[i] <= '0;
         end
      end else if (cmd.apply) begin
         cnt_ff[sel]  <= nxt_z[15:0];
         mode_ff[sel] <= cur_mode | flags;
         prem_ff[sel] <= div_r_ff;
      end else if (cmd.reg_op && op_ff == OP_WRITE && sel_ok) begin
         case (addr_ff[10:0])
            OFS_COUNT: cnt_ff[sel]  <= wdata_ff[15:0];
            OFS_MODE:  mode_ff[sel] <= (cur_mode & MODE_FLAG_MASK & ~(wdata_ff & MODE_FLAG_MASK))
                                       | (wdata_ff & ~MODE_FLAG_MASK);
            OFS_COMP:  comp_ff[sel] <= wdata_ff[15:0];
            OFS_HOLD:  hold_ff[sel] <= wdata_ff[15:0];
            default:   ;
         endcase
      end
   end

   assign rsp_read_data = out_rd_ff;
   assign rsp_irq_lines = out_irq_ff;

endmodule
